// File: design/qpe_pkg.sv
// ----------------------------------------------------------------------------
// qpe_pkg: shared types and constants of the QOI pixel encoder
// Op codes, cache geometry, the per-pixel op descriptor and the cache hash.
// ----------------------------------------------------------------------------
package qpe_pkg;

  localparam int unsigned CACHE_DEPTH = 64;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned RUN_W       = 6;
  localparam int unsigned RUN_CAP     = 62;
  localparam int unsigned PAD_LEN     = 8;
  localparam int unsigned MAX_OUT     = 13;
  localparam int unsigned HOLD_LIMIT  = MAX_OUT - PAD_LEN;
  localparam int unsigned MAX_OPS     = 6;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned SLOT_W      = 4;

  localparam logic [7:0]  OP_DIFF    = 8'h40;
  localparam logic [7:0]  OP_LUMA    = 8'h80;
  localparam logic [7:0]  OP_RUN     = 8'hc0;
  localparam logic [7:0]  OP_RGB     = 8'hfe;
  localparam logic [7:0]  OP_RGBA    = 8'hff;
  localparam logic [7:0]  PAD_FILL   = 8'h00;
  localparam logic [7:0]  PAD_END    = 8'h01;
  localparam logic [31:0] PREV_RESET = 32'h0000_00ff;

  typedef logic [7:0] octet_t;

  // One pixel's worth of output: optional spilled end marker, up to six op
  // bytes (run flush plus the widest op), then the padding if last.
  typedef struct packed {
    logic                      spill;
    logic                      pad;
    logic                      hold;
    logic [CNT_W-1:0]          cnt;
    logic [MAX_OPS-1:0][7:0]   ops;
  } desc_t;

  function automatic logic [IDX_W-1:0] cache_index(input logic [7:0] r,
                                                    input logic [7:0] g,
                                                    input logic [7:0] b,
                                                    input logic [7:0] a);
    logic [IDX_W-1:0] s;
    s = r[IDX_W-1:0] * IDX_W'(3) + g[IDX_W-1:0] * IDX_W'(5)
      + b[IDX_W-1:0] * IDX_W'(7) + a[IDX_W-1:0] * IDX_W'(11);
    return s;
  endfunction

endpackage

// File: design/qpe_if.sv
// ----------------------------------------------------------------------------
// qpe_if: valid/ready channels of the QOI pixel encoder
// Pixel request channel and encoded byte channel.
// ----------------------------------------------------------------------------
interface qpe_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_pixel;

  modport source (output valid, red, green, blue, alpha, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, alpha, last_pixel, output ready);
endinterface

interface qpe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       item_done;
  logic       stream_done;

  modport source (output valid, out_byte, item_done, stream_done, input ready);
  modport sink   (input valid, out_byte, item_done, stream_done, output ready);
endinterface

// File: design/qpe_front.sv
// ----------------------------------------------------------------------------
// qpe_front: pixel intake, colour cache and op classification
// Reads the cache on accept, classifies the pixel in the next cycle and emits
// one op descriptor per pixel that yields bytes.
// ----------------------------------------------------------------------------
module qpe_front import qpe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qpe_pixel_if.sink   pixel,
  output desc_t       desc,
  output logic        desc_valid,
  input  logic        desc_ready
);

  logic [31:0]            cache_mem [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] cache_vld;
  logic [31:0]            cache_q;

  logic                   take;
  logic [IDX_W-1:0]       rd_idx;
  logic                   wr_hit;

  logic                   s1_valid;
  logic [31:0]            s1_px;
  logic                   s1_last;
  logic [IDX_W-1:0]       s1_idx;
  logic                   ent_vld;
  logic                   ent_fwd;
  logic [31:0]            ent_fwd_px;

  logic [31:0]            prev_px;
  logic [RUN_W-1:0]       run_len;
  logic                   spill;

  logic [31:0]            entry;
  logic [7:0]             r, g, b, a, pr, pg, pb, pa;
  logic signed [7:0]      vr, vg, vb, vgr, vgb;
  logic [7:0]             dr, dg, db, lg, lr, lb;
  logic                   is_diff, is_luma, same;
  logic [RUN_W-1:0]       run_inc, run_next, run_code;
  logic                   flush, we, push_need, s1_adv;
  logic [MAX_OPS-1:0][7:0] ob;
  logic [CNT_W-1:0]       ocnt;

  assign take   = pixel.valid && pixel.ready;
  assign rd_idx = cache_index(pixel.red, pixel.green, pixel.blue, pixel.alpha);

  // Cache entry as seen by the pixel in stage one, after bypass and clear.
  assign entry = ent_vld ? (ent_fwd ? ent_fwd_px : cache_q) : 32'h0;

  assign r  = s1_px[31:24];
  assign g  = s1_px[23:16];
  assign b  = s1_px[15:8];
  assign a  = s1_px[7:0];
  assign pr = prev_px[31:24];
  assign pg = prev_px[23:16];
  assign pb = prev_px[15:8];
  assign pa = prev_px[7:0];

  assign vr  = r - pr;
  assign vg  = g - pg;
  assign vb  = b - pb;
  assign vgr = vr - vg;
  assign vgb = vb - vg;
  assign dr  = vr + 8'd2;
  assign dg  = vg + 8'd2;
  assign db  = vb + 8'd2;
  assign lg  = vg + 8'd32;
  assign lr  = vgr + 8'd8;
  assign lb  = vgb + 8'd8;

  assign is_diff = (vr >= -8'sd2) && (vr <= 8'sd1) && (vg >= -8'sd2) && (vg <= 8'sd1)
                && (vb >= -8'sd2) && (vb <= 8'sd1);
  assign is_luma = (vgr >= -8'sd8) && (vgr <= 8'sd7) && (vg >= -8'sd32)
                && (vg <= 8'sd31) && (vgb >= -8'sd8) && (vgb <= 8'sd7);

  assign same    = (s1_px == prev_px);
  assign run_inc = run_len + RUN_W'(1);

  always_comb begin
    ob       = '0;
    ocnt     = '0;
    flush    = 1'b0;
    we       = 1'b0;
    run_next = run_len;
    run_code = run_len - RUN_W'(1);
    if (same) begin
      if (run_inc >= RUN_W'(RUN_CAP) || s1_last) begin
        flush    = 1'b1;
        run_code = run_len;
        run_next = '0;
      end else begin
        run_next = run_inc;
      end
    end else begin
      flush    = (run_len != '0);
      run_next = '0;
      if (entry == s1_px) begin
        ob[0] = {2'b00, s1_idx};
        ocnt  = CNT_W'(1);
      end else begin
        we = 1'b1;
        if (a == pa) begin
          if (is_diff) begin
            ob[0] = OP_DIFF | {2'b00, dr[1:0], dg[1:0], db[1:0]};
            ocnt  = CNT_W'(1);
          end else if (is_luma) begin
            ob[0] = OP_LUMA | {2'b00, lg[5:0]};
            ob[1] = {lr[3:0], lb[3:0]};
            ocnt  = CNT_W'(2);
          end else begin
            ob[0] = OP_RGB;
            ob[1] = r;
            ob[2] = g;
            ob[3] = b;
            ocnt  = CNT_W'(4);
          end
        end else begin
          ob[0] = OP_RGBA;
          ob[1] = r;
          ob[2] = g;
          ob[3] = b;
          ob[4] = a;
          ocnt  = CNT_W'(5);
        end
      end
    end
  end

  // Pack the run flush ahead of the op bytes.
  always_comb begin
    desc.spill  = spill;
    desc.pad    = s1_last;
    desc.cnt    = ocnt + CNT_W'(flush);
    desc.hold   = s1_last
               && ((CNT_W + 1)'(spill) + (CNT_W + 1)'(desc.cnt) > (CNT_W + 1)'(HOLD_LIMIT));
    desc.ops[0] = flush ? (OP_RUN | {2'b00, run_code}) : ob[0];
    for (int i = 1; i < MAX_OPS; i++) begin
      desc.ops[i] = flush ? ob[i-1] : ob[i];
    end
  end

  assign push_need   = spill || (desc.cnt != '0) || s1_last;
  assign desc_valid  = s1_valid && push_need;
  assign s1_adv      = s1_valid && (!push_need || desc_ready);
  assign pixel.ready = !s1_valid || s1_adv;
  assign wr_hit      = s1_adv && we && !s1_last && (s1_idx == rd_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      prev_px   <= PREV_RESET;
      run_len   <= '0;
      spill     <= 1'b0;
      cache_vld <= '0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        spill <= desc.hold;
        if (s1_last) begin
          prev_px   <= PREV_RESET;
          run_len   <= '0;
          cache_vld <= '0;
        end else begin
          prev_px <= s1_px;
          run_len <= run_next;
          if (we) begin
            cache_vld[s1_idx] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_px      <= {pixel.red, pixel.green, pixel.blue, pixel.alpha};
      s1_last    <= pixel.last_pixel;
      s1_idx     <= rd_idx;
      ent_vld    <= (s1_adv && s1_last) ? 1'b0 : (wr_hit || cache_vld[rd_idx]);
      ent_fwd    <= wr_hit;
      ent_fwd_px <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && we) begin
      cache_mem[s1_idx] <= s1_px;
    end
    if (take) begin
      cache_q <= cache_mem[rd_idx];
    end
  end

endmodule

// File: design/qpe_queue.sv
// ----------------------------------------------------------------------------
// qpe_queue: descriptor queue between front and back
// Small register FIFO; lets classification and byte output stall apart.
// ----------------------------------------------------------------------------
module qpe_queue import qpe_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  desc_t in_data,
  input  logic  in_valid,
  output logic  in_ready,
  output desc_t out_data,
  output logic  out_valid,
  input  logic  out_ready
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

// File: design/qpe_back.sv
// ----------------------------------------------------------------------------
// qpe_back: byte serialiser
// Walks one descriptor slot per unstalled cycle into a registered byte output.
// ----------------------------------------------------------------------------
module qpe_back import qpe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  desc_t       desc,
  input  logic        desc_valid,
  output logic        desc_ready,
  qpe_byte_if.source  code
);

  desc_t             cur;
  logic              cur_valid;
  logic [SLOT_W-1:0] pos;
  logic [SLOT_W-1:0] len;
  logic [SLOT_W-1:0] q;
  logic [SLOT_W-1:0] k;
  logic              last_slot;
  logic              emit;

  logic [7:0]        slot_byte;
  logic              slot_item;
  logic              slot_stream;

  logic              o_valid;
  logic [7:0]        o_byte;
  logic              o_item;
  logic              o_stream;

  assign len = SLOT_W'(cur.spill) + SLOT_W'(cur.cnt)
             + (cur.pad ? (cur.hold ? SLOT_W'(PAD_LEN - 1) : SLOT_W'(PAD_LEN)) : '0);
  assign q   = pos - SLOT_W'(cur.spill);
  assign k   = q - SLOT_W'(cur.cnt);

  always_comb begin
    if (cur.spill && pos == '0) begin
      slot_byte   = PAD_END;
      slot_item   = 1'b1;
      slot_stream = 1'b1;
    end else if (q < SLOT_W'(cur.cnt)) begin
      slot_byte   = cur.ops[q[CNT_W-1:0]];
      slot_item   = (q == SLOT_W'(cur.cnt) - SLOT_W'(1)) && !cur.pad;
      slot_stream = 1'b0;
    end else begin
      slot_byte   = (k == SLOT_W'(PAD_LEN - 1)) ? PAD_END : PAD_FILL;
      slot_item   = (k == SLOT_W'(PAD_LEN - 1));
      slot_stream = (k == SLOT_W'(PAD_LEN - 1));
    end
  end

  assign last_slot  = (pos == len - SLOT_W'(1));
  assign emit       = cur_valid && (!o_valid || code.ready);
  assign desc_ready = !cur_valid || (emit && last_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
      o_valid   <= 1'b0;
    end else begin
      if (desc_valid && desc_ready) begin
        cur_valid <= 1'b1;
        pos       <= '0;
      end else if (emit && last_slot) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        pos <= pos + SLOT_W'(1);
      end
      if (emit) begin
        o_valid <= 1'b1;
      end else if (code.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid && desc_ready) begin
      cur <= desc;
    end
    if (emit) begin
      o_byte   <= slot_byte;
      o_item   <= slot_item;
      o_stream <= slot_stream;
    end
  end

  assign code.valid       = o_valid;
  assign code.out_byte    = o_byte;
  assign code.item_done   = o_item;
  assign code.stream_done = o_stream;

endmodule

// File: design/qoi_pixel_encoder_core.sv
// ----------------------------------------------------------------------------
// qoi_pixel_encoder_core: QOI op stream encoder, one RGBA8 pixel per request
// A pixel's first byte goes through stage one, the queue, the serialiser's
// descriptor register and the output register. Throughput: one byte per cycle
// while the receiver takes it, so 1 to 5 bytes per pixel (6 with a run flush,
// plus 8 padding bytes on the last pixel); the byte-wide output register sets
// that rate; run-extending pixels give no bytes. Reset (rst, synchronous):
// clears pipeline, queue, run and all cache valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
module qoi_pixel_encoder_core import qpe_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  qpe_pixel_if.sink   pixel,
  qpe_byte_if.source  code
);

  // Front part: takes a pixel request when stage one is free or advancing,
  // reads the colour cache in the same edge and classifies the pixel in the
  // following cycle against the previous pixel and the cache entry. A write
  // to the same cache slot by the preceding pixel is bypassed, and the cache
  // is wiped at once after the last pixel of an image.
  desc_t f_desc;
  logic  f_valid;
  logic  f_ready;

  // Back part: serialises one descriptor slot per cycle into the output register
  // while bytes are taken; while one waits, pixels flow on until the queue fills.
  desc_t b_desc;
  logic  b_valid;
  logic  b_ready;

  qpe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .desc       (f_desc),
    .desc_valid (f_valid),
    .desc_ready (f_ready)
  );

  // Queue between the two parts: each side holds on its own stall.
  qpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_data   (f_desc),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_data  (b_desc),
    .out_valid (b_valid),
    .out_ready (b_ready)
  );

  // An end-of-image marker that does not fit in a pixel's byte budget is
  // carried in the front part and sent ahead of the next pixel's bytes.
  qpe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc       (b_desc),
    .desc_valid (b_valid),
    .desc_ready (b_ready),
    .code       (code)
  );

endmodule

// File: design/qpe_checker.sv
// ----------------------------------------------------------------------------
// qpe_checker: port-level checks of the QOI pixel encoder
// Output handshake, end marker and post-reset state, bound to the top level.
// ----------------------------------------------------------------------------
module qpe_checker import qpe_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       item_done,
  input logic       stream_done
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(item_done)
                               && $stable(stream_done))
    else $error("output payload changed while stalled");

  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> item_done && out_byte == PAD_END)
    else $error("end of stream not on the final padding byte");

  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("encoder not idle after reset");

endmodule

bind qoi_pixel_encoder_core qpe_checker u_qpe_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (pixel.ready),
  .out_valid   (code.valid),
  .out_ready   (code.ready),
  .out_byte    (code.out_byte),
  .item_done   (code.item_done),
  .stream_done (code.stream_done)
);

// File: tb/tb_qoi_pixel_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qoi_pixel_encoder_core: self-checking bench for the QOI pixel encoder
// Pixel requests drive the encoder. Its own encoder model turns each request
// into the op bytes that must come out. The model keeps the colour cache, the
// previous pixel, the run counter and the spilled end marker. A directed stimulus table
// comes first, then randomised images, under three idle mixes and two pressure
// points.
// ----------------------------------------------------------------------------
module tb_qoi_pixel_encoder_core;
  import qpe_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int LONG_HOLD     = 400;   // receiver hold-off, long enough to fill the queue
  localparam int SETTLE_CYCLES = 10;    // pipeline settling time plus margin
  localparam int PHASE_ITEMS   = 80;

  // One expected byte of the encoded stream
  typedef struct packed {
    octet_t value;
    logic   item_end;
    logic   image_end;
  } enc_byte_t;

  // Directed stimulus: a pixel, repeated reps times. Where n_ops is not
  // negative the op bytes (high byte first) are typed in and replace the
  // model's own op bytes; padding and the spilled marker are always added.
  typedef struct {
    octet_t      r, g, b, a;
    bit          last;
    int          reps;
    int          n_ops;
    logic [47:0] ops;
  } stim_row_t;

  logic clk;
  logic rst;

  qpe_pixel_if pix_ch ();
  qpe_byte_if  code_ch ();

  qoi_pixel_encoder_core dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pix_ch),
    .code  (code_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Encoder model state
  // --------------------------------------------------------------------------
  logic [31:0]  colour_cache [CACHE_DEPTH];
  logic [31:0]  prev_px;
  int unsigned  run_len;
  bit           spill_pending;
  octet_t       pixel_ops [$];     // op bytes of the pixel being modelled
  enc_byte_t    awaited_bytes [$]; // bytes still to come out, oldest first

  // Bench state shared between processes
  int           n_errors;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           test_phase;
  int           hold_left;
  bit           hold_done;
  logic [31:0]  sent_px;
  logic [31:0]  recent_px [8];
  logic [2:0]   recent_wr;

  // Directed rows. The image starts fresh: previous pixel is opaque black and
  // every cache entry is zero.
  stim_row_t stim_rows [18] = '{
    // transparent black hashes to slot zero, which already holds it: INDEX 0
    '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1,  1, 48'h00_0000000000},
    // white with a new alpha: RGBA
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1,  5, 48'hffffffffff_00},
    // run that reaches the cap and goes out on its own
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 62, -1, 48'h0},
    // run extension only: no bytes at all
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 5,  0, 48'h0},
    // flush the run, then a DIFF of +1 on each channel that wraps past 255
    '{8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 1,  2, 48'hc47f_00000000},
    '{8'd2,   8'd3,   8'd3,   8'd255, 1'b0, 1,  2, 48'ha378_00000000},
    '{8'd201, 8'd100, 8'd50,  8'd255, 1'b0, 1,  4, 48'hfec96432_0000},
    // white is still cached: INDEX
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1,  1, 48'h26_0000000000},
    '{8'd0,   8'd0,   8'd0,   8'd128, 1'b0, 1,  5, 48'hff00000080_00},
    // LUMA at both ends of its ranges
    '{8'd216, 8'd224, 8'd231, 8'd128, 1'b0, 1,  2, 48'h800f_00000000},
    '{8'd254, 8'd255, 8'd254, 8'd128, 1'b0, 1,  2, 48'hbff0_00000000},
    // DIFF at its low end
    '{8'd252, 8'd253, 8'd252, 8'd128, 1'b0, 1,  1, 48'h40_0000000000},
    '{8'd252, 8'd253, 8'd252, 8'd128, 1'b0, 3,  0, 48'h0},
    // last pixel: run flush, RGBA and padding overflow the byte limit
    '{8'd10,  8'd20,  8'd30,  8'd40,  1'b1, 1,  6, 48'hc2ff0a141e28},
    // next image: run extension that only releases the spilled marker
    '{8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 1,  0, 48'h0},
    '{8'd1,   8'd2,   8'd3,   8'd4,   1'b1, 1,  6, 48'hc0ff01020304},
    // spilled marker ahead of a 13-byte last pixel spills once more
    '{8'd9,   8'd9,   8'd9,   8'd9,   1'b1, 1,  5, 48'hff09090909_00},
    // single-pixel image that is a run of one
    '{8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 1,  1, 48'hc0_0000000000}
  };

  // --------------------------------------------------------------------------
  // Encoder model
  // --------------------------------------------------------------------------
  task automatic clear_image;
    foreach (colour_cache[i]) colour_cache[i] = '0;
    prev_px = PREV_RESET;
    run_len = 0;
  endtask

  // Work out the op bytes of one pixel into pixel_ops and advance the state
  task automatic encode_pixel(input logic [31:0] px, input bit last);
    octet_t           r, g, b, a, pr, pg, pb, pa;
    byte              vr, vg, vb, vgr, vgb;
    logic [IDX_W-1:0] slot;
    r = px[31:24];
    g = px[23:16];
    b = px[15:8];
    a = px[7:0];
    pixel_ops.delete();
    if (px == prev_px) begin
      run_len++;
      if (run_len >= RUN_CAP || last) begin
        pixel_ops.push_back(OP_RUN | octet_t'(run_len - 1));
        run_len = 0;
      end
    end else begin
      slot = IDX_W'((int'(r) * 3 + int'(g) * 5 + int'(b) * 7 + int'(a) * 11) % CACHE_DEPTH);
      if (run_len > 0) begin
        pixel_ops.push_back(OP_RUN | octet_t'(run_len - 1));
        run_len = 0;
      end
      if (colour_cache[slot] == px) begin
        pixel_ops.push_back(octet_t'(slot));
      end else begin
        pr = prev_px[31:24];
        pg = prev_px[23:16];
        pb = prev_px[15:8];
        pa = prev_px[7:0];
        colour_cache[slot] = px;
        if (a == pa) begin
          // differences wrap to 8 bits and are read as signed
          vr  = r - pr;
          vg  = g - pg;
          vb  = b - pb;
          vgr = vr - vg;
          vgb = vb - vg;
          if (vr >= -2 && vr <= 1 && vg >= -2 && vg <= 1 && vb >= -2 && vb <= 1) begin
            pixel_ops.push_back(OP_DIFF | octet_t'(((vr + 2) << 4) | ((vg + 2) << 2) |
                                                   (vb + 2)));
          end else if (vgr >= -8 && vgr <= 7 && vg >= -32 && vg <= 31 &&
                       vgb >= -8 && vgb <= 7) begin
            pixel_ops.push_back(OP_LUMA | octet_t'(vg + 32));
            pixel_ops.push_back(octet_t'(((vgr + 8) << 4) | (vgb + 8)));
          end else begin
            pixel_ops.push_back(OP_RGB);
            pixel_ops.push_back(r);
            pixel_ops.push_back(g);
            pixel_ops.push_back(b);
          end
        end else begin
          pixel_ops.push_back(OP_RGBA);
          pixel_ops.push_back(r);
          pixel_ops.push_back(g);
          pixel_ops.push_back(b);
          pixel_ops.push_back(a);
        end
      end
    end
    prev_px = px;
    if (last) clear_image();
  endtask

  // Turn pixel_ops into awaited bytes: spilled marker first, then the ops and
  // padding, cut at the per-pixel byte limit
  task automatic queue_pixel_bytes(input bit last);
    octet_t seq [$];
    int     n;
    bit     final_byte;
    seq = pixel_ops;
    if (last) begin
      repeat (PAD_LEN - 1) seq.push_back(PAD_FILL);
      seq.push_back(PAD_END);
    end
    n = 0;
    if (spill_pending) begin
      awaited_bytes.push_back('{PAD_END, 1'b1, 1'b1});
      spill_pending = 1'b0;
      n = 1;
    end
    foreach (seq[i]) begin
      final_byte = (i == seq.size() - 1);
      if (n >= MAX_OUT) begin
        spill_pending = 1'b1;
        break;
      end
      awaited_bytes.push_back('{seq[i], final_byte, final_byte && last});
      n++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Pixel request side
  // --------------------------------------------------------------------------
  // Offer one pixel at the falling edge, hold it until taken, then model it.
  // Where typed_n is not negative the typed op bytes stand in for the model's.
  task automatic send_pixel(input logic [31:0] px, input bit last, input int typed_n,
                            input logic [47:0] typed_ops);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_ch.valid = 1'b0;
      @(negedge clk);
    end
    pix_ch.valid      = 1'b1;
    pix_ch.red        = px[31:24];
    pix_ch.green      = px[23:16];
    pix_ch.blue       = px[15:8];
    pix_ch.alpha      = px[7:0];
    pix_ch.last_pixel = last;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    encode_pixel(px, last);
    if (typed_n >= 0) begin
      pixel_ops.delete();
      for (int k = 0; k < typed_n; k++) pixel_ops.push_back(typed_ops[47 - 8 * k -: 8]);
    end
    queue_pixel_bytes(last);
    sent_px = px;
  endtask

  // Mostly well-formed image content: runs, cache hits, small steps, with
  // some wholly random pixels and the odd end of image
  task automatic random_pixels(input int n_items);
    int          sent;
    int          mode;
    int          reps;
    int          dg;
    logic [31:0] px;
    bit          last;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(0, 99);
      reps = 1;
      px   = sent_px;
      if (mode < 25) begin
        // hold the same pixel: short runs, now and then past the cap
        reps = ($urandom_range(0, 15) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 4);
      end else if (mode < 40) begin
        px = recent_px[3'($urandom_range(0, 7))];
      end else if (mode < 58) begin
        px[31:24] = px[31:24] + octet_t'($urandom_range(0, 3)) - 8'd2;
        px[23:16] = px[23:16] + octet_t'($urandom_range(0, 3)) - 8'd2;
        px[15:8]  = px[15:8]  + octet_t'($urandom_range(0, 3)) - 8'd2;
      end else if (mode < 76) begin
        dg = $urandom_range(0, 63) - 32;
        px[23:16] = px[23:16] + octet_t'(dg);
        px[31:24] = px[31:24] + octet_t'(dg + $urandom_range(0, 15) - 8);
        px[15:8]  = px[15:8]  + octet_t'(dg + $urandom_range(0, 15) - 8);
      end else if (mode < 90) begin
        px[31:8] = 24'($urandom());
      end else begin
        px = $urandom();
      end
      for (int k = 0; k < reps; k++) begin
        last = (k == reps - 1) && ($urandom_range(0, 39) == 0);
        send_pixel(px, last, -1, '0);
        sent++;
      end
      recent_px[recent_wr] = px;
      recent_wr = recent_wr + 3'd1;
    end
  endtask

  // Drop the request and wait for every awaited byte, then let the pipeline
  // settle so that nothing stray follows
  task automatic drain_bytes;
    @(negedge clk);
    pix_ch.valid = 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Byte side: ready pattern and the long hold-off, counted here
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      code_ch.ready = 1'b0;
      hold_left--;
    end else if (test_phase == 3 && !hold_done) begin
      // starve the output while requests keep coming, so the input stalls
      hold_done     = 1'b1;
      hold_left     = LONG_HOLD - 1;
      code_ch.ready = 1'b0;
    end else begin
      code_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each byte taken with the oldest awaited one
  always @(posedge clk) begin
    enc_byte_t want;
    if (!rst && code_ch.valid === 1'b1 && code_ch.ready === 1'b1) begin
      if (awaited_bytes.size() == 0) begin
        $error("unexpected byte: out_byte %0h item_done %0b stream_done %0b",
               code_ch.out_byte, code_ch.item_done, code_ch.stream_done);
        n_errors++;
      end else begin
        want = awaited_bytes.pop_front();
        if (code_ch.out_byte !== want.value) begin
          $error("out_byte: expected %0h, got %0h", want.value, code_ch.out_byte);
          n_errors++;
        end
        if (code_ch.item_done !== want.item_end) begin
          $error("item_done: expected %0b, got %0b", want.item_end, code_ch.item_done);
          n_errors++;
        end
        if (code_ch.stream_done !== want.image_end) begin
          $error("stream_done: expected %0b, got %0b", want.image_end, code_ch.stream_done);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    pix_ch.valid      = 1'b0;
    pix_ch.red        = '0;
    pix_ch.green      = '0;
    pix_ch.blue       = '0;
    pix_ch.alpha      = '0;
    pix_ch.last_pixel = 1'b0;
    code_ch.ready     = 1'b0;
    n_errors          = 0;
    cycle_count       = 0;
    hold_left         = 0;
    hold_done         = 1'b0;
    recent_wr         = '0;
    spill_pending     = 1'b0;
    sent_px           = PREV_RESET;
    foreach (recent_px[i]) recent_px[i] = $urandom();
    clear_image();

    // first mix: sender idles lightly, receiver heavily
    send_idle_pct = 20;
    recv_idle_pct = 82;
    test_phase    = 1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_rows[i]) begin
      for (int k = 0; k < stim_rows[i].reps; k++) begin
        send_pixel({stim_rows[i].r, stim_rows[i].g, stim_rows[i].b, stim_rows[i].a},
                   stim_rows[i].last, stim_rows[i].n_ops, stim_rows[i].ops);
      end
    end
    random_pixels(PHASE_ITEMS);
    // pause the sender until every awaited byte is out
    drain_bytes();

    // second mix: the other way round
    send_idle_pct = 82;
    recv_idle_pct = 20;
    test_phase    = 2;
    random_pixels(PHASE_ITEMS);
    drain_bytes();

    // third mix: no idling, apart from the long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_phase    = 3;
    random_pixels(PHASE_ITEMS);

    // close the open image with a run pixel, which also releases any
    // spilled end marker
    send_pixel(prev_px, 1'b1, -1, '0);
    drain_bytes();

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
design/qpe_pkg.sv
design/qpe_if.sv
design/qpe_front.sv
design/qpe_queue.sv
design/qpe_back.sv
design/qoi_pixel_encoder_core.sv
design/qpe_checker.sv
tb/tb_qoi_pixel_encoder_core.sv
